// ===== rtl/tbs_pkg.sv =====
package tbs_pkg;

   localparam int MAX_TITLES_DEF = 16;
   localparam int MAX_CHARS_DEF  = 99;
   localparam int POS_W          = 4;
   localparam int CHAR_W         = 8;

   typedef struct packed {
      logic [CHAR_W-1:0] char_code;
      logic              has_char;
      logic              end_of_title;
      logic              end_of_list;
   } req_type;

   typedef struct packed {
      logic [POS_W-1:0] title_position;
      logic             last_in_order;
   } rsp_type;

   typedef enum logic [3:0] {
      S_LOAD,
      S_INIT,
      S_PASS_RD0,
      S_PASS_LEN0,
      S_PASS_CARRY,
      S_CAND_RD,
      S_CAND_LEN,
      S_CAND_SET,
      S_CMP,
      S_CMP_B,
      S_CMP_D,
      S_PLACE,
      S_PASS_END,
      S_EMIT_RD,
      S_EMIT_LD,
      S_EMIT_WAIT
   } state_type;

   typedef enum logic [3:0] {
      OP_LOAD,
      OP_INIT,
      OP_RD0,
      OP_LEN0,
      OP_CARRY,
      OP_CAND_RD,
      OP_CAND_LEN,
      OP_CAND_SET,
      OP_CMP,
      OP_CMP_B,
      OP_CMP_D,
      OP_PLACE,
      OP_PASS_END,
      OP_EMIT_RD,
      OP_EMIT_LD,
      OP_EMIT_WAIT
   } op_type;

   typedef struct packed {
      op_type op;
      logic   fire;
   } cmd_type;

   typedef struct packed {
      logic load_sort;
      logic init_last;
      logic n_one;
      logic cmp_end;
      logic chars_differ;
      logic pass_last;
      logic limit_one;
      logic emit_last;
   } status_type;

endpackage

// ===== rtl/title_bubble_sorter.sv =====
// Title sorter. The req channel carries one beat per title character, with
// end_of_title closing a title and end_of_list closing the list. Character
// beats are taken one per cycle. After the end_of_list beat, req_stall rises
// while the block bubble-sorts an order table of load positions into strcmp
// order (stable) and then sends one rsp beat per title in sorted order, the
// final one flagged by last_in_order. An empty list sends nothing.
// Sort steps: the order table is seeded with one entry per title, then n-1
// passes each read the first entry and its length and compare each remaining
// pair; a comparison fetches both titles' bytes in turn through the single
// read port of the character memory, over the shared prefix and then either
// the differing byte or the end of the shorter title. Each rsp beat goes
// through an order table read, an output register load and the handoff.
// When the receiver raises rsp_stall, the current rsp beat holds and the
// emit sequence waits; req stays stalled until the last rsp beat is taken.
// Reset (synchronous) empties the list and clears any pending rsp beat; the
// memories need no clearing pass.
module title_bubble_sorter #(
   parameter int MAX_TITLES = tbs_pkg::MAX_TITLES_DEF,
   parameter int MAX_CHARS  = tbs_pkg::MAX_CHARS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tbs_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tbs_pkg::rsp_type rsp_payload
);

   tbs_pkg::cmd_type    cmd;
   tbs_pkg::status_type status;

   tbs_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .rsp_stall(rsp_stall),
      .status   (status),
      .cmd      (cmd),
      .req_stall(req_stall)
   );

   tbs_datapath #(
      .MAX_TITLES(MAX_TITLES),
      .MAX_CHARS (MAX_CHARS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_payload(req_payload),
      .status     (status),
      .rsp_valid  (rsp_valid),
      .rsp_payload(rsp_payload)
   );

   a_no_load_while_emit: assert property (
      @(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall
   ) else $error("req beat open while rsp beat pending");

   a_load_continues: assert property (
      @(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !req_payload.end_of_list) |=> !req_stall
   ) else $error("req stalled after a plain character beat");

   a_last_frees_input: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_payload.last_in_order) |=> (!req_stall && !rsp_valid)
   ) else $error("block not idle after last rsp beat");

endmodule

// ===== rtl/tbs_ram.sv =====
module tbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/tbs_ctrl.sv =====
module tbs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                rsp_stall,
   input  tbs_pkg::status_type status,
   output tbs_pkg::cmd_type    cmd,
   output logic                req_stall
);

   tbs_pkg::state_type state_ff;
   tbs_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tbs_pkg::S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd.op    = tbs_pkg::OP_LOAD;
      cmd.fire  = 1'b0;
      req_stall = 1'b1;
      unique case (state_ff)
         tbs_pkg::S_LOAD: begin
            req_stall = 1'b0;
            cmd.op    = tbs_pkg::OP_LOAD;
            cmd.fire  = req_valid;
            if (req_valid && status.load_sort) begin
               state_in = tbs_pkg::S_INIT;
            end
         end
         tbs_pkg::S_INIT: begin
            cmd.op = tbs_pkg::OP_INIT;
            if (status.init_last) begin
               state_in = status.n_one ? tbs_pkg::S_EMIT_RD : tbs_pkg::S_PASS_RD0;
            end
         end
         tbs_pkg::S_PASS_RD0: begin
            cmd.op   = tbs_pkg::OP_RD0;
            state_in = tbs_pkg::S_PASS_LEN0;
         end
         tbs_pkg::S_PASS_LEN0: begin
            cmd.op   = tbs_pkg::OP_LEN0;
            state_in = tbs_pkg::S_PASS_CARRY;
         end
         tbs_pkg::S_PASS_CARRY: begin
            cmd.op   = tbs_pkg::OP_CARRY;
            state_in = tbs_pkg::S_CAND_RD;
         end
         tbs_pkg::S_CAND_RD: begin
            cmd.op   = tbs_pkg::OP_CAND_RD;
            state_in = tbs_pkg::S_CAND_LEN;
         end
         tbs_pkg::S_CAND_LEN: begin
            cmd.op   = tbs_pkg::OP_CAND_LEN;
            state_in = tbs_pkg::S_CAND_SET;
         end
         tbs_pkg::S_CAND_SET: begin
            cmd.op   = tbs_pkg::OP_CAND_SET;
            state_in = tbs_pkg::S_CMP;
         end
         tbs_pkg::S_CMP: begin
            cmd.op   = tbs_pkg::OP_CMP;
            state_in = status.cmp_end ? tbs_pkg::S_PLACE : tbs_pkg::S_CMP_B;
         end
         tbs_pkg::S_CMP_B: begin
            cmd.op   = tbs_pkg::OP_CMP_B;
            state_in = tbs_pkg::S_CMP_D;
         end
         tbs_pkg::S_CMP_D: begin
            cmd.op   = tbs_pkg::OP_CMP_D;
            state_in = status.chars_differ ? tbs_pkg::S_PLACE : tbs_pkg::S_CMP;
         end
         tbs_pkg::S_PLACE: begin
            cmd.op   = tbs_pkg::OP_PLACE;
            state_in = status.pass_last ? tbs_pkg::S_PASS_END : tbs_pkg::S_CAND_RD;
         end
         tbs_pkg::S_PASS_END: begin
            cmd.op   = tbs_pkg::OP_PASS_END;
            state_in = status.limit_one ? tbs_pkg::S_EMIT_RD : tbs_pkg::S_PASS_RD0;
         end
         tbs_pkg::S_EMIT_RD: begin
            cmd.op   = tbs_pkg::OP_EMIT_RD;
            state_in = tbs_pkg::S_EMIT_LD;
         end
         tbs_pkg::S_EMIT_LD: begin
            cmd.op   = tbs_pkg::OP_EMIT_LD;
            state_in = tbs_pkg::S_EMIT_WAIT;
         end
         tbs_pkg::S_EMIT_WAIT: begin
            cmd.op   = tbs_pkg::OP_EMIT_WAIT;
            cmd.fire = !rsp_stall;
            if (!rsp_stall) begin
               state_in = status.emit_last ? tbs_pkg::S_LOAD : tbs_pkg::S_EMIT_RD;
            end
         end
      endcase
   end

endmodule

// ===== rtl/tbs_datapath.sv =====
module tbs_datapath #(
   parameter int MAX_TITLES = tbs_pkg::MAX_TITLES_DEF,
   parameter int MAX_CHARS  = tbs_pkg::MAX_CHARS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  tbs_pkg::cmd_type    cmd,
   input  tbs_pkg::req_type    req_payload,
   output tbs_pkg::status_type status,
   output logic                rsp_valid,
   output tbs_pkg::rsp_type    rsp_payload
);

   localparam int CW      = $clog2(MAX_TITLES + 1);
   localparam int PW      = $clog2(MAX_TITLES);
   localparam int KW      = $clog2(MAX_CHARS + 1);
   localparam int DEPTH_C = MAX_TITLES * MAX_CHARS;
   localparam int AW      = $clog2(DEPTH_C);

   logic [CW-1:0] title_count_ff, title_count_in;
   logic [KW-1:0] char_index_ff, char_index_in;
   logic [CW-1:0] n_ff, n_in;
   logic [PW-1:0] j_ff, j_in;
   logic [PW-1:0] limit_ff, limit_in;
   logic [PW-1:0] carry_pos_ff, carry_pos_in;
   logic [KW-1:0] carry_len_ff, carry_len_in;
   logic [PW-1:0] cand_pos_ff, cand_pos_in;
   logic [KW-1:0] cand_len_ff, cand_len_in;
   logic [KW-1:0] k_ff, k_in;
   logic [tbs_pkg::CHAR_W-1:0] a_char_ff, a_char_in;
   logic less_ff, less_in;
   logic rsp_valid_ff, rsp_valid_in;
   tbs_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic          ord_wr_en, ord_rd_en;
   logic [PW-1:0] ord_wr_addr, ord_rd_addr, ord_wr_data, ord_rd_data;
   logic          len_wr_en, len_rd_en;
   logic [PW-1:0] len_wr_addr, len_rd_addr;
   logic [KW-1:0] len_wr_data, len_rd_data;
   logic          chr_wr_en, chr_rd_en;
   logic [AW-1:0] chr_wr_addr, chr_rd_addr;
   logic [tbs_pkg::CHAR_W-1:0] chr_wr_data, chr_rd_data;

   logic          store_char, close_title, do_close;
   logic [KW-1:0] idx_after, min_len;
   logic [CW-1:0] count_after;
   logic [PW-1:0] sel_pos;
   logic [AW-1:0] sel_base;

   assign store_char = req_payload.has_char && (req_payload.char_code != '0)
                       && (title_count_ff < CW'(MAX_TITLES))
                       && (char_index_ff < KW'(MAX_CHARS));
   assign idx_after   = char_index_ff + KW'(store_char);
   assign close_title = req_payload.end_of_title
                        || (req_payload.end_of_list && (idx_after != '0));
   assign do_close    = close_title && (title_count_ff < CW'(MAX_TITLES));
   assign count_after = title_count_ff + CW'(do_close);
   assign min_len     = (cand_len_ff < carry_len_ff) ? cand_len_ff : carry_len_ff;
   assign sel_pos     = (cmd.op == tbs_pkg::OP_CMP_B) ? carry_pos_ff : cand_pos_ff;
   assign sel_base    = AW'(sel_pos) * AW'(MAX_CHARS);

   assign status.load_sort    = req_payload.end_of_list && (count_after != '0);
   assign status.init_last    = (CW'(j_ff) + CW'(1)) == n_ff;
   assign status.n_one        = n_ff == CW'(1);
   assign status.cmp_end      = k_ff == min_len;
   assign status.chars_differ = a_char_ff != chr_rd_data;
   assign status.pass_last    = (j_ff + PW'(1)) == limit_ff;
   assign status.limit_one    = limit_ff == PW'(1);
   assign status.emit_last    = (CW'(j_ff) + CW'(1)) == n_ff;

   always_comb begin
      title_count_in = title_count_ff;
      char_index_in  = char_index_ff;
      n_in           = n_ff;
      j_in           = j_ff;
      limit_in       = limit_ff;
      carry_pos_in   = carry_pos_ff;
      carry_len_in   = carry_len_ff;
      cand_pos_in    = cand_pos_ff;
      cand_len_in    = cand_len_ff;
      k_in           = k_ff;
      a_char_in      = a_char_ff;
      less_in        = less_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      ord_wr_en      = 1'b0;
      ord_wr_addr    = j_ff;
      ord_wr_data    = j_ff;
      ord_rd_en      = 1'b0;
      ord_rd_addr    = j_ff;
      len_wr_en      = 1'b0;
      len_wr_addr    = PW'(title_count_ff);
      len_wr_data    = idx_after;
      len_rd_en      = 1'b0;
      len_rd_addr    = ord_rd_data;
      chr_wr_en      = 1'b0;
      chr_wr_addr    = AW'(title_count_ff) * AW'(MAX_CHARS) + AW'(char_index_ff);
      chr_wr_data    = req_payload.char_code;
      chr_rd_en      = 1'b0;
      chr_rd_addr    = sel_base + AW'(k_ff);
      unique case (cmd.op)
         tbs_pkg::OP_LOAD: begin
            if (cmd.fire) begin
               chr_wr_en      = store_char;
               len_wr_en      = do_close;
               title_count_in = count_after;
               char_index_in  = close_title ? '0 : idx_after;
               if (req_payload.end_of_list) begin
                  title_count_in = '0;
                  char_index_in  = '0;
                  n_in           = count_after;
                  j_in           = '0;
               end
            end
         end
         tbs_pkg::OP_INIT: begin
            ord_wr_en = 1'b1;
            if (status.init_last) begin
               j_in     = '0;
               limit_in = PW'(n_ff - CW'(1));
            end else begin
               j_in = j_ff + PW'(1);
            end
         end
         tbs_pkg::OP_RD0: begin
            ord_rd_en   = 1'b1;
            ord_rd_addr = '0;
         end
         tbs_pkg::OP_LEN0: begin
            len_rd_en    = 1'b1;
            carry_pos_in = ord_rd_data;
         end
         tbs_pkg::OP_CARRY: begin
            carry_len_in = len_rd_data;
         end
         tbs_pkg::OP_CAND_RD: begin
            ord_rd_en   = 1'b1;
            ord_rd_addr = j_ff + PW'(1);
         end
         tbs_pkg::OP_CAND_LEN: begin
            len_rd_en   = 1'b1;
            cand_pos_in = ord_rd_data;
         end
         tbs_pkg::OP_CAND_SET: begin
            cand_len_in = len_rd_data;
            k_in        = '0;
         end
         tbs_pkg::OP_CMP: begin
            if (status.cmp_end) begin
               less_in = cand_len_ff < carry_len_ff;
            end else begin
               chr_rd_en = 1'b1;
            end
         end
         tbs_pkg::OP_CMP_B: begin
            chr_rd_en = 1'b1;
            a_char_in = chr_rd_data;
         end
         tbs_pkg::OP_CMP_D: begin
            if (status.chars_differ) begin
               less_in = a_char_ff < chr_rd_data;
            end else begin
               k_in = k_ff + KW'(1);
            end
         end
         tbs_pkg::OP_PLACE: begin
            ord_wr_en   = 1'b1;
            ord_wr_data = less_ff ? cand_pos_ff : carry_pos_ff;
            if (!less_ff) begin
               carry_pos_in = cand_pos_ff;
               carry_len_in = cand_len_ff;
            end
            if (!status.pass_last) begin
               j_in = j_ff + PW'(1);
            end
         end
         tbs_pkg::OP_PASS_END: begin
            ord_wr_en   = 1'b1;
            ord_wr_addr = limit_ff;
            ord_wr_data = carry_pos_ff;
            j_in        = '0;
            limit_in    = limit_ff - PW'(1);
         end
         tbs_pkg::OP_EMIT_RD: begin
            ord_rd_en = 1'b1;
         end
         tbs_pkg::OP_EMIT_LD: begin
            rsp_valid_in               = 1'b1;
            rsp_data_in.title_position = tbs_pkg::POS_W'(ord_rd_data);
            rsp_data_in.last_in_order  = status.emit_last;
         end
         tbs_pkg::OP_EMIT_WAIT: begin
            if (cmd.fire) begin
               rsp_valid_in = 1'b0;
               if (!status.emit_last) begin
                  j_in = j_ff + PW'(1);
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         title_count_ff <= '0;
         char_index_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         title_count_ff <= title_count_in;
         char_index_ff  <= char_index_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      j_ff         <= j_in;
      limit_ff     <= limit_in;
      carry_pos_ff <= carry_pos_in;
      carry_len_ff <= carry_len_in;
      cand_pos_ff  <= cand_pos_in;
      cand_len_ff  <= cand_len_in;
      k_ff         <= k_in;
      a_char_ff    <= a_char_in;
      less_ff      <= less_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   tbs_ram #(
      .WIDTH(PW),
      .DEPTH(MAX_TITLES)
   ) u_order_ram (
      .clock  (clock),
      .wr_en  (ord_wr_en),
      .wr_addr(ord_wr_addr),
      .wr_data(ord_wr_data),
      .rd_en  (ord_rd_en),
      .rd_addr(ord_rd_addr),
      .rd_data(ord_rd_data)
   );

   tbs_ram #(
      .WIDTH(KW),
      .DEPTH(MAX_TITLES)
   ) u_length_ram (
      .clock  (clock),
      .wr_en  (len_wr_en),
      .wr_addr(len_wr_addr),
      .wr_data(len_wr_data),
      .rd_en  (len_rd_en),
      .rd_addr(len_rd_addr),
      .rd_data(len_rd_data)
   );

   tbs_ram #(
      .WIDTH(tbs_pkg::CHAR_W),
      .DEPTH(DEPTH_C)
   ) u_char_ram (
      .clock  (clock),
      .wr_en  (chr_wr_en),
      .wr_addr(chr_wr_addr),
      .wr_data(chr_wr_data),
      .rd_en  (chr_rd_en),
      .rd_addr(chr_rd_addr),
      .rd_data(chr_rd_data)
   );

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

   localparam int MAX_TITLES = tbs_pkg::MAX_TITLES_DEF;
   localparam int MAX_CHARS  = tbs_pkg::MAX_CHARS_DEF;
   localparam int LIMIT      = 1000000;
   localparam int HOLD_LEN   = 300;
   localparam int TAIL_LEN   = 40;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   tbs_pkg::req_type req_payload = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   tbs_pkg::rsp_type rsp_payload;

   title_bubble_sorter #(
      .MAX_TITLES(MAX_TITLES),
      .MAX_CHARS (MAX_CHARS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   tbs_pkg::req_type char_beats[$];
   tbs_pkg::rsp_type pending_ranks[$];

   logic [7:0]  shelf_chars [MAX_TITLES][MAX_CHARS];
   int unsigned shelf_len [MAX_TITLES];
   int unsigned shelf_count = 0;
   int unsigned open_len = 0;

   int unsigned idle_pct = 0;
   int unsigned stall_pct = 0;
   bit          pressure_armed = 1'b0;
   bit          hold_used = 1'b0;
   int unsigned hold_left = 0;

   int unsigned beats_queued = 0;
   int unsigned beats_taken = 0;
   int unsigned lists_sorted = 0;
   int unsigned ranks_seen = 0;
   int unsigned rank_errors = 0;
   int unsigned cycle_count = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int title_cmp(int unsigned x, int unsigned y);
      int unsigned k;
      int unsigned span;
      span = (shelf_len[x] < shelf_len[y]) ? shelf_len[x] : shelf_len[y];
      for (k = 0; k < span; k++) begin
         if (shelf_chars[x][k] != shelf_chars[y][k])
            return (shelf_chars[x][k] < shelf_chars[y][k]) ? -1 : 1;
      end
      if (shelf_len[x] == shelf_len[y])
         return 0;
      return (shelf_len[x] < shelf_len[y]) ? -1 : 1;
   endfunction

   function automatic void sort_shelf();
      int unsigned      order [MAX_TITLES];
      int unsigned      i;
      int unsigned      j;
      int unsigned      swap;
      tbs_pkg::rsp_type rank;
      for (i = 0; i < shelf_count; i++)
         order[i] = i;
      for (i = 1; i < shelf_count; i++) begin
         for (j = 0; j + i < shelf_count; j++) begin
            if (title_cmp(order[j + 1], order[j]) < 0) begin
               swap = order[j];
               order[j] = order[j + 1];
               order[j + 1] = swap;
            end
         end
      end
      for (i = 0; i < shelf_count; i++) begin
         rank.title_position = tbs_pkg::POS_W'(order[i]);
         rank.last_in_order = (i + 1 == shelf_count);
         pending_ranks.push_back(rank);
      end
   endfunction

   function automatic void absorb_beat(tbs_pkg::req_type b);
      if (b.has_char && b.char_code != 0 && shelf_count < MAX_TITLES
          && open_len < MAX_CHARS) begin
         shelf_chars[shelf_count][open_len] = b.char_code;
         open_len++;
      end
      if (b.end_of_title || (b.end_of_list && open_len > 0)) begin
         if (shelf_count < MAX_TITLES) begin
            shelf_len[shelf_count] = open_len;
            shelf_count++;
         end
         open_len = 0;
      end
      if (b.end_of_list) begin
         sort_shelf();
         shelf_count = 0;
         open_len = 0;
         lists_sorted++;
      end
   endfunction

   function automatic void check_rank(tbs_pkg::rsp_type got);
      tbs_pkg::rsp_type want;
      ranks_seen++;
      if (pending_ranks.size() == 0) begin
         rank_errors++;
         if (rank_errors <= 10)
            $display("%0t: unexpected rank beat pos=%0d last=%0b", $realtime,
                     got.title_position, got.last_in_order);
         return;
      end
      want = pending_ranks.pop_front();
      if (got.title_position !== want.title_position
          || got.last_in_order !== want.last_in_order) begin
         rank_errors++;
         if (rank_errors <= 10)
            $display("%0t: rank mismatch: expected pos=%0d last=%0b, got pos=%0d last=%0b",
                     $realtime, want.title_position, want.last_in_order,
                     got.title_position, got.last_in_order);
      end
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_payload <= '0;
      end else begin
         if (req_valid && !req_stall) begin
            absorb_beat(req_payload);
            beats_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (char_beats.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
               req_valid <= 1'b1;
               req_payload <= char_beats.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold, once
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (pressure_armed && !hold_used && rsp_valid) begin
         hold_left <= HOLD_LEN;
         hold_used <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            check_rank(rsp_payload);
         rsp_stall <= (hold_left > 1) || ($urandom_range(0, 99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic push_beat(input logic [7:0] code, input bit has, input bit eot,
                            input bit eol);
      tbs_pkg::req_type b;
      b.char_code = code;
      b.has_char = has;
      b.end_of_title = eot;
      b.end_of_list = eol;
      char_beats.push_back(b);
      beats_queued++;
   endtask

   function automatic logic [7:0] pick_char();
      int unsigned r;
      r = $urandom_range(0, 19);
      if (r < 13)
         return 8'(8'h61 + $urandom_range(0, 2));
      else if (r < 14)
         return 8'h00;
      else if (r < 15)
         return 8'hFF;
      else if (r < 16)
         return 8'h01;
      return 8'($urandom_range(1, 255));
   endfunction

   function automatic int unsigned pick_titles();
      int unsigned r;
      r = $urandom_range(0, 19);
      if (r == 0)
         return 0;
      else if (r < 3)
         return $urandom_range(13, 18);
      return $urandom_range(1, 7);
   endfunction

   task automatic random_list(input int unsigned titles);
      int unsigned t;
      int unsigned k;
      int unsigned len;
      int unsigned style;
      bit          last;
      bit          eol_done;
      eol_done = 1'b0;
      for (t = 0; t < titles; t++) begin
         last = (t + 1 == titles);
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 4);
         for (k = 0; k + 1 < len; k++) begin
            if ($urandom_range(0, 11) == 0)
               push_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
            push_beat(pick_char(), 1'b1, 1'b0, 1'b0);
         end
         style = last ? $urandom_range(0, 2) : $urandom_range(0, 1);
         if (len == 0) begin
            eol_done = last && $urandom_range(0, 1);
            push_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1, eol_done);
         end else if (style == 0) begin
            eol_done = last && $urandom_range(0, 1);
            push_beat(pick_char(), 1'b1, 1'b1, eol_done);
         end else if (style == 1) begin
            push_beat(pick_char(), 1'b1, 1'b0, 1'b0);
            eol_done = last && $urandom_range(0, 1);
            push_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1, eol_done);
         end else begin
            push_beat(pick_char(), 1'b1, 1'b0, 1'b1);
            eol_done = 1'b1;
         end
      end
      if (!eol_done)
         push_beat(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0, 1'b0, 1'b1);
   endtask

   task automatic random_phase(input int unsigned budget);
      int unsigned goal;
      goal = beats_queued + budget;
      while (beats_queued < goal)
         random_list(pick_titles());
   endtask

   // a title cut at the length limit must tie with an equal full-length title and keep load order
   task automatic long_list();
      int unsigned k;
      for (k = 0; k < MAX_CHARS; k++)
         push_beat(8'h6D, 1'b1, 1'b0, 1'b0);
      push_beat(8'h7A, 1'b1, 1'b0, 1'b0);
      push_beat(8'h7A, 1'b1, 1'b1, 1'b0);
      for (k = 0; k + 1 < MAX_CHARS; k++)
         push_beat(8'h6D, 1'b1, 1'b0, 1'b0);
      push_beat(8'h6D, 1'b1, 1'b1, 1'b0);
      push_beat(8'h6D, 1'b1, 1'b1, 1'b1);
   endtask

   task automatic wait_drained();
      while (char_beats.size() != 0 || req_valid || pending_ranks.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // empty list
      push_beat(8'h00, 1'b0, 1'b0, 1'b1);
      // byte extremes, empty title, zero byte, unclosed title at list end
      push_beat(8'hFF, 1'b1, 1'b1, 1'b0);
      push_beat(8'h01, 1'b1, 1'b1, 1'b0);
      push_beat(8'hA5, 1'b0, 1'b1, 1'b0);
      push_beat(8'h00, 1'b1, 1'b0, 1'b0);
      push_beat(8'h01, 1'b1, 1'b0, 1'b0);
      push_beat(8'hFF, 1'b1, 1'b1, 1'b0);
      push_beat(8'h5A, 1'b0, 1'b0, 1'b0);
      push_beat(8'h80, 1'b1, 1'b0, 1'b1);
      // prefix order and ties
      push_beat(8'h61, 1'b1, 1'b0, 1'b0);
      push_beat(8'h62, 1'b1, 1'b1, 1'b0);
      push_beat(8'h61, 1'b1, 1'b1, 1'b0);
      push_beat(8'h61, 1'b1, 1'b0, 1'b0);
      push_beat(8'h62, 1'b1, 1'b1, 1'b0);
      push_beat(8'h62, 1'b1, 1'b1, 1'b0);
      push_beat(8'h00, 1'b0, 1'b0, 1'b1);
      // single title, close and end on one beat
      push_beat(8'h71, 1'b1, 1'b1, 1'b1);
      // zero byte on the end beat of an empty list
      push_beat(8'h00, 1'b1, 1'b0, 1'b1);

      random_phase(20);
      long_list();
      pressure_armed = 1'b1;
      random_list(14);
      random_list(6);
      wait_drained();

      idle_pct = 57;
      stall_pct = 0;
      random_phase(20);
      wait_drained();

      idle_pct = 0;
      stall_pct = 57;
      random_phase(20);
      wait_drained();

      idle_pct = 33;
      stall_pct = 33;
      random_phase(20);
      wait_drained();

      repeat (TAIL_LEN) @(posedge clock);

      $display("Sorted %0d lists from %0d beats; %0d ranks checked, %0d mismatches.",
               lists_sorted, beats_taken, ranks_seen, rank_errors);
      $display("Idle and stall mixes, full and truncated titles, ties and one long hold.");
      if (rank_errors == 0 && pending_ranks.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
